// ===== rtl/ose_pkg.sv =====
// Shared constants, codes and types of the overlap SSD error block.
package ose_pkg;

    // Largest block side that the counters support.
    localparam int MAX_BLOCK_EDGE = 64;
    localparam int CNT_W          = $clog2(MAX_BLOCK_EDGE);
    localparam int CFG_W          = 7;
    localparam int CMP_W          = (CFG_W > CNT_W + 1) ? CFG_W : CNT_W + 1;
    localparam int PIX_W          = 8;
    localparam int SQ_W           = 2 * PIX_W;
    localparam int ADD_W          = SQ_W + 2;
    localparam int SUM_W          = 30;
    localparam int MODE_W         = 2;
    localparam int IDX_W          = 2;
    localparam int FIFO_DEPTH     = 4;
    localparam int PTR_W          = $clog2(FIFO_DEPTH);

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    // Configuration register indexes.
    localparam logic [IDX_W-1:0] REG_BLOCK_EDGE    = 2'd0;
    localparam logic [IDX_W-1:0] REG_OVERLAP_WIDTH = 2'd1;
    localparam logic [IDX_W-1:0] REG_OVERLAP_MODE  = 2'd2;

    // Overlap mode codes.
    localparam logic [MODE_W-1:0] MODE_LEFT   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_TOP    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CORNER = 2'd2;

    localparam logic [CFG_W-1:0]  RST_BLOCK_EDGE    = 7'd32;
    localparam logic [CFG_W-1:0]  RST_OVERLAP_WIDTH = 7'd6;
    localparam logic [MODE_W-1:0] RST_OVERLAP_MODE  = MODE_LEFT;

    // One classified pixel pair on its way from the front to the back.
    typedef struct packed {
        logic [PIX_W-1:0] cand_red;
        logic [PIX_W-1:0] cand_green;
        logic [PIX_W-1:0] cand_blue;
        logic [PIX_W-1:0] tgt_red;
        logic [PIX_W-1:0] tgt_green;
        logic [PIX_W-1:0] tgt_blue;
        logic             counts;
        logic             last;
    } ose_entry_t;

endpackage

// ===== rtl/overlap_ssd_error.sv =====
// Top level of the overlap squared-difference error block.
//
// The feeder streams the pixel pairs of one square candidate block in raster
// order on the s_ channel, one beat per pair. The front classifies each beat
// by its row and column against the overlap strip, a four-entry queue holds
// classified beats, and the back adds the squared RGB differences of the
// beats that count. At the last pixel of the block one beat carrying the
// total appears on the m_ channel; every other input beat produces nothing.
// Configuration writes arrive on the cfg_ channel, which is always ready.
// Throughput is one pixel pair per cycle while the queue has room, set by the
// combinational square and accumulate stage of the back. The last pixel passes
// through the queue, behind any beats queued ahead of it, into the result
// register that drives m_valid. When the receiver stalls, the result waits there
// and the back goes on adding the next block until its closing beat waits at the
// queue head; up to three more beats queue behind it, and s_ready falls once the
// queue is full. A synchronous reset on aresetn clears the counters, the
// accumulator, the queue and m_valid, and loads side 32, strip 6, left mode.
module overlap_ssd_error (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [ose_pkg::IDX_W-1:0]    cfg_index,
    input  logic [ose_pkg::CFG_W-1:0]    cfg_data,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [ose_pkg::PIX_W-1:0]    s_cand_red,
    input  logic [ose_pkg::PIX_W-1:0]    s_cand_green,
    input  logic [ose_pkg::PIX_W-1:0]    s_cand_blue,
    input  logic [ose_pkg::PIX_W-1:0]    s_tgt_red,
    input  logic [ose_pkg::PIX_W-1:0]    s_tgt_green,
    input  logic [ose_pkg::PIX_W-1:0]    s_tgt_blue,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [ose_pkg::SUM_W-1:0]    m_block_error
);
    import ose_pkg::*;

    logic       q_full;
    logic       q_push;
    logic       q_pop;
    logic       q_not_empty;
    ose_entry_t q_in_entry;
    ose_entry_t q_head_entry;

    ose_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_cand_red   (s_cand_red),
        .s_cand_green (s_cand_green),
        .s_cand_blue  (s_cand_blue),
        .s_tgt_red    (s_tgt_red),
        .s_tgt_green  (s_tgt_green),
        .s_tgt_blue   (s_tgt_blue),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_entry      (q_in_entry)
    );

    ose_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_in_entry),
        .full       (q_full),
        .pop        (q_pop),
        .not_empty  (q_not_empty),
        .head_entry (q_head_entry)
    );

    ose_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_not_empty   (q_not_empty),
        .q_entry       (q_head_entry),
        .q_pop         (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_block_error (m_block_error)
    );

endmodule

// ===== rtl/ose_front.sv =====
// Front end: configuration registers, position counters and overlap classification.
module ose_front (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [ose_pkg::IDX_W-1:0]    cfg_index,
    input  logic [ose_pkg::CFG_W-1:0]    cfg_data,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [ose_pkg::PIX_W-1:0]    s_cand_red,
    input  logic [ose_pkg::PIX_W-1:0]    s_cand_green,
    input  logic [ose_pkg::PIX_W-1:0]    s_cand_blue,
    input  logic [ose_pkg::PIX_W-1:0]    s_tgt_red,
    input  logic [ose_pkg::PIX_W-1:0]    s_tgt_green,
    input  logic [ose_pkg::PIX_W-1:0]    s_tgt_blue,
    input  logic                         q_full,
    output logic                         q_push,
    output ose_pkg::ose_entry_t          q_entry
);
    import ose_pkg::*;

    logic [CFG_W-1:0]  block_edge_reg, block_edge_next;
    logic [CFG_W-1:0]  overlap_width_reg, overlap_width_next;
    logic [MODE_W-1:0] overlap_mode_reg, overlap_mode_next;
    logic [CNT_W-1:0]  row_count_reg, row_count_next;
    logic [CNT_W-1:0]  col_count_reg, col_count_next;

    logic [CMP_W-1:0] edge_raw;
    logic [CMP_W-1:0] edge_use;
    logic [CMP_W-1:0] width_ext;
    logic [CMP_W-1:0] col_inc;
    logic [CMP_W-1:0] row_inc;
    logic             in_left;
    logic             in_top;
    logic             counts;
    logic             last_col;
    logic             last_row;
    logic             accept;

    assign cfg_ready = 1'b1;
    assign s_ready   = !q_full;
    assign accept    = s_valid && s_ready;
    assign q_push    = accept;

    always_comb begin
        block_edge_next    = block_edge_reg;
        overlap_width_next = overlap_width_reg;
        overlap_mode_next  = overlap_mode_reg;
        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_BLOCK_EDGE:    block_edge_next    = cfg_data;
                REG_OVERLAP_WIDTH: overlap_width_next = cfg_data;
                REG_OVERLAP_MODE:  overlap_mode_next  = cfg_data[MODE_W-1:0];
                default: ;
            endcase
        end
    end

    // The side in use is the programmed side held to the supported range.
    always_comb begin
        edge_raw = CMP_W'(block_edge_reg);
        if (edge_raw < CMP_W'(2)) begin
            edge_use = CMP_W'(2);
        end else if (edge_raw > CMP_W'(MAX_BLOCK_EDGE)) begin
            edge_use = CMP_W'(MAX_BLOCK_EDGE);
        end else begin
            edge_use = edge_raw;
        end
    end

    assign width_ext = CMP_W'(overlap_width_reg);
    assign col_inc   = CMP_W'(col_count_reg) + CMP_W'(1);
    assign row_inc   = CMP_W'(row_count_reg) + CMP_W'(1);
    assign in_left   = CMP_W'(col_count_reg) < width_ext;
    assign in_top    = CMP_W'(row_count_reg) < width_ext;
    assign last_col  = col_inc >= edge_use;
    assign last_row  = row_inc >= edge_use;

    always_comb begin
        case (overlap_mode_reg)
            MODE_LEFT:   counts = in_left;
            MODE_CORNER: counts = in_left || in_top;
            default:     counts = in_top;
        endcase
    end

    always_comb begin
        row_count_next = row_count_reg;
        col_count_next = col_count_reg;
        if (accept) begin
            if (last_col && last_row) begin
                row_count_next = '0;
                col_count_next = '0;
            end else if (last_col) begin
                col_count_next = '0;
                row_count_next = row_inc[CNT_W-1:0];
            end else begin
                col_count_next = col_inc[CNT_W-1:0];
            end
        end
    end

    always_comb begin
        q_entry.cand_red   = s_cand_red;
        q_entry.cand_green = s_cand_green;
        q_entry.cand_blue  = s_cand_blue;
        q_entry.tgt_red    = s_tgt_red;
        q_entry.tgt_green  = s_tgt_green;
        q_entry.tgt_blue   = s_tgt_blue;
        q_entry.counts     = counts;
        q_entry.last       = last_col && last_row;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            block_edge_reg    <= RST_BLOCK_EDGE;
            overlap_width_reg <= RST_OVERLAP_WIDTH;
            overlap_mode_reg  <= RST_OVERLAP_MODE;
            row_count_reg     <= '0;
            col_count_reg     <= '0;
        end else begin
            block_edge_reg    <= block_edge_next;
            overlap_width_reg <= overlap_width_next;
            overlap_mode_reg  <= overlap_mode_next;
            row_count_reg     <= row_count_next;
            col_count_reg     <= col_count_next;
        end
    end

    // A beat that closes a block leaves both counters at the origin.
    a_wrap_to_origin: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && q_entry.last) |=> (row_count_reg == '0 && col_count_reg == '0))
        else $error("counters did not wrap after the last pixel");

endmodule

// ===== rtl/ose_fifo.sv =====
// Short queue of classified pixel pairs between the front and the back.
module ose_fifo (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  ose_pkg::ose_entry_t push_entry,
    output logic                full,
    input  logic                pop,
    output logic                not_empty,
    output ose_pkg::ose_entry_t head_entry
);
    import ose_pkg::*;

    ose_entry_t       mem [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   count_reg, count_next;

    assign full       = count_reg == (PTR_W + 1)'(FIFO_DEPTH);
    assign not_empty  = count_reg != '0;
    assign head_entry = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + (PTR_W + 1)'(1);
        end else if (pop && !push) begin
            count_next = count_reg - (PTR_W + 1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> count_reg != '0)
        else $error("queue popped while empty");

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (count_reg != (PTR_W + 1)'(FIFO_DEPTH)) || pop)
        else $error("queue pushed while full");

    a_ptr_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        PTR_W'(wr_ptr_reg - rd_ptr_reg) == count_reg[PTR_W-1:0])
        else $error("queue pointers disagree with the fill count");

endmodule

// ===== rtl/ose_back.sv =====
// Back end: squared channel differences, saturating accumulator and result register.
module ose_back (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         q_not_empty,
    input  ose_pkg::ose_entry_t          q_entry,
    output logic                         q_pop,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [ose_pkg::SUM_W-1:0]    m_block_error
);
    import ose_pkg::*;

    logic [SUM_W-1:0] error_sum_reg, error_sum_next;
    logic             out_valid_reg, out_valid_next;
    logic [SUM_W-1:0] out_data_reg, out_data_next;

    logic [PIX_W-1:0] diff_r, diff_g, diff_b;
    logic [SQ_W-1:0]  sq_r, sq_g, sq_b;
    logic [ADD_W-1:0] add_val;
    logic [SUM_W:0]   sum_wide;
    logic [SUM_W-1:0] sum_sat;
    logic [SUM_W-1:0] sum_after;
    logic             slot_free;

    always_comb begin
        diff_r = (q_entry.cand_red > q_entry.tgt_red) ?
                 q_entry.cand_red - q_entry.tgt_red : q_entry.tgt_red - q_entry.cand_red;
        diff_g = (q_entry.cand_green > q_entry.tgt_green) ?
                 q_entry.cand_green - q_entry.tgt_green :
                 q_entry.tgt_green - q_entry.cand_green;
        diff_b = (q_entry.cand_blue > q_entry.tgt_blue) ?
                 q_entry.cand_blue - q_entry.tgt_blue : q_entry.tgt_blue - q_entry.cand_blue;
        sq_r    = SQ_W'(diff_r) * SQ_W'(diff_r);
        sq_g    = SQ_W'(diff_g) * SQ_W'(diff_g);
        sq_b    = SQ_W'(diff_b) * SQ_W'(diff_b);
        add_val = ADD_W'(sq_r) + ADD_W'(sq_g) + ADD_W'(sq_b);
        sum_wide = {1'b0, error_sum_reg} + (SUM_W + 1)'(add_val);
        sum_sat  = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
        sum_after = q_entry.counts ? sum_sat : error_sum_reg;
    end

    // A closing beat may leave the queue only when the result register can take it.
    assign slot_free = !out_valid_reg || m_ready;
    assign q_pop     = q_not_empty && (!q_entry.last || slot_free);

    always_comb begin
        error_sum_next = error_sum_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_data_next  = out_data_reg;
        if (q_pop) begin
            if (q_entry.last) begin
                error_sum_next = '0;
                out_valid_next = 1'b1;
                out_data_next  = sum_after;
            end else begin
                error_sum_next = sum_after;
            end
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            error_sum_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            error_sum_reg <= error_sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_block_error = out_data_reg;

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop && q_entry.last) |-> (!out_valid_reg || m_ready))
        else $error("result register overwritten before it was taken");

    a_sum_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop && q_entry.last) |=> error_sum_reg == '0)
        else $error("accumulator not cleared after a block");

    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop && q_entry.last) |=> out_valid_reg)
        else $error("closing beat produced no result");

endmodule

// ===== bench/overlap_error_checker.sv =====
// Checker for the overlap SSD error block: predicts each block total and compares result beats.
module overlap_error_checker (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_valid,
    input  logic                      cfg_ready,
    input  logic [ose_pkg::IDX_W-1:0] cfg_index,
    input  logic [ose_pkg::CFG_W-1:0] cfg_data,
    input  logic                      s_valid,
    input  logic                      s_ready,
    input  logic [ose_pkg::PIX_W-1:0] s_cand_red,
    input  logic [ose_pkg::PIX_W-1:0] s_cand_green,
    input  logic [ose_pkg::PIX_W-1:0] s_cand_blue,
    input  logic [ose_pkg::PIX_W-1:0] s_tgt_red,
    input  logic [ose_pkg::PIX_W-1:0] s_tgt_green,
    input  logic [ose_pkg::PIX_W-1:0] s_tgt_blue,
    input  logic                      m_valid,
    input  logic                      m_ready,
    input  logic [ose_pkg::SUM_W-1:0] m_block_error,
    output int                        fail_count,
    output int                        pending_results,
    output int                        results_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    import ose_pkg::*;

    logic [CFG_W-1:0]  cur_side;
    logic [CFG_W-1:0]  cur_strip;
    logic [MODE_W-1:0] cur_mode;
    logic [CNT_W-1:0]  row_pos;
    logic [CNT_W-1:0]  col_pos;
    logic [SUM_W-1:0]  run_sum;
    logic [SUM_W-1:0]  oldest_error;
    logic [SUM_W-1:0]  expected_block_errors[$];

    function automatic int unsigned channel_sq(input logic [PIX_W-1:0] a,
                                               input logic [PIX_W-1:0] b);
        int unsigned d;
        d = (a > b) ? 32'(a - b) : 32'(b - a);
        return d * d;
    endfunction

    // Advances the block position by one pixel pair and queues the total at the block's end.
    task automatic accumulate_overlap_pixel(input logic [PIX_W-1:0] cr, input logic [PIX_W-1:0] cg,
                                            input logic [PIX_W-1:0] cb, input logic [PIX_W-1:0] tr,
                                            input logic [PIX_W-1:0] tg, input logic [PIX_W-1:0] tb);
        int                side;
        logic              in_left;
        logic              in_top;
        logic              counted;
        logic              end_col;
        logic              end_row;
        longint unsigned   total;
        side = int'(cur_side);
        if (side < 2)
            side = 2;
        if (side > MAX_BLOCK_EDGE)
            side = MAX_BLOCK_EDGE;
        in_left = col_pos < cur_strip;
        in_top  = row_pos < cur_strip;
        case (cur_mode)
            MODE_LEFT:   counted = in_left;
            MODE_CORNER: counted = in_left || in_top;
            default:     counted = in_top;
        endcase
        if (counted) begin
            total = longint'(run_sum) + channel_sq(cr, tr) + channel_sq(cg, tg)
                    + channel_sq(cb, tb);
            run_sum = (total > SUM_MAX) ? SUM_MAX : SUM_W'(total);
        end
        // A counter left past a shrunken side by a mid-block write closes that row or block.
        end_col = int'(col_pos) + 1 >= side;
        end_row = int'(row_pos) + 1 >= side;
        if (end_col && end_row) begin
            expected_block_errors.push_back(run_sum);
            run_sum = '0;
            row_pos = '0;
            col_pos = '0;
        end else if (end_col) begin
            col_pos = '0;
            row_pos = row_pos + 1'b1;
        end else begin
            col_pos = col_pos + 1'b1;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            cur_side        = RST_BLOCK_EDGE;
            cur_strip       = RST_OVERLAP_WIDTH;
            cur_mode        = RST_OVERLAP_MODE;
            row_pos         = '0;
            col_pos         = '0;
            run_sum         = '0;
            fail_count      = 0;
            results_checked = 0;
            expected_block_errors.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_block_errors.size() == 0) begin
                    $error("block_error beat with nothing expected: actual %0d", m_block_error);
                    fail_count++;
                end else begin
                    oldest_error = expected_block_errors.pop_front();
                    results_checked++;
                    if (m_block_error !== oldest_error) begin
                        $error("block_error mismatch: expected %0d, actual %0d",
                               oldest_error, m_block_error);
                        fail_count++;
                    end
                end
            end
            if (s_valid && s_ready)
                accumulate_overlap_pixel(s_cand_red, s_cand_green, s_cand_blue,
                                         s_tgt_red, s_tgt_green, s_tgt_blue);
            // A write on the same edge as a pixel takes effect from the next pixel on.
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_BLOCK_EDGE:    cur_side  = cfg_data;
                    REG_OVERLAP_WIDTH: cur_strip = cfg_data;
                    REG_OVERLAP_MODE:  cur_mode  = cfg_data[MODE_W-1:0];
                    default: ;
                endcase
            end
        end
        pending_results = expected_block_errors.size();
    end

endmodule

// ===== bench/tb_overlap_ssd_error.sv =====
// Top-level testbench of the overlap SSD error block: clock, reset, stimulus and verdict.
module tb_overlap_ssd_error;
    timeunit 1ns;
    timeprecision 1ps;

    import ose_pkg::*;

    localparam int DRAIN_CYCLES = 12;
    localparam int LONG_STALL   = 300;
    localparam int RANDOM_PAIRS = 1750;
    localparam int QUIET_TAIL   = 300;
    localparam int STALL_PHASE  = 2;
    localparam int TIMEOUT_NS   = 1_000_000;

    // The block treats the unnamed mode code like the top strip.
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    logic             aclk          = 1'b0;
    logic             aresetn       = 1'b0;
    logic             cfg_valid     = 1'b0;
    logic             cfg_ready;
    logic [IDX_W-1:0] cfg_index     = '0;
    logic [CFG_W-1:0] cfg_data      = '0;
    logic             s_valid       = 1'b0;
    logic             s_ready;
    logic [PIX_W-1:0] s_cand_red    = '0;
    logic [PIX_W-1:0] s_cand_green  = '0;
    logic [PIX_W-1:0] s_cand_blue   = '0;
    logic [PIX_W-1:0] s_tgt_red     = '0;
    logic [PIX_W-1:0] s_tgt_green   = '0;
    logic [PIX_W-1:0] s_tgt_blue    = '0;
    logic             m_valid;
    logic             m_ready       = 1'b0;
    logic [SUM_W-1:0] m_block_error;

    int   fail_count;
    int   pending_results;
    int   results_checked;
    int   pixel_pairs_sent = 0;
    int   settings_applied = 0;
    bit   quiet            = 1'b0;
    bit   stall_request    = 1'b0;
    bit   stall_served     = 1'b0;

    always #1 aclk = ~aclk;

    overlap_ssd_error dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cand_red    (s_cand_red),
        .s_cand_green  (s_cand_green),
        .s_cand_blue   (s_cand_blue),
        .s_tgt_red     (s_tgt_red),
        .s_tgt_green   (s_tgt_green),
        .s_tgt_blue    (s_tgt_blue),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_block_error (m_block_error)
    );

    overlap_error_checker checker_i (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_cand_red      (s_cand_red),
        .s_cand_green    (s_cand_green),
        .s_cand_blue     (s_cand_blue),
        .s_tgt_red       (s_tgt_red),
        .s_tgt_green     (s_tgt_green),
        .s_tgt_blue      (s_tgt_blue),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_block_error   (m_block_error),
        .fail_count      (fail_count),
        .pending_results (pending_results),
        .results_checked (results_checked)
    );

    initial begin
        #(TIMEOUT_NS);
        $display("Timeout with %0d block results still outstanding", pending_results);
        $display("Simulation FAILED");
        $finish;
    end

    // Result side: short random stalls, and one long hold-off when the stimulus asks for it.
    initial begin
        forever begin
            @(negedge aclk);
            if (stall_request && !stall_served) begin
                stall_served = 1'b1;
                m_ready <= 1'b0;
                repeat (LONG_STALL - 1) @(negedge aclk);
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(0, 5)) @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    function automatic logic [PIX_W-1:0] pick_channel();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return PIX_W'($urandom);
        endcase
    endfunction

    // Register tasks leave cfg_valid high between back-to-back beats; write_config drops it.
    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
    endtask

    task automatic write_config(input logic [CFG_W-1:0] side_v, input logic [CFG_W-1:0] strip_v,
                                input logic [MODE_W-1:0] mode_v);
        write_reg(REG_BLOCK_EDGE, side_v);
        write_reg(REG_OVERLAP_WIDTH, strip_v);
        write_reg(REG_OVERLAP_MODE, CFG_W'(mode_v));
        cfg_valid <= 1'b0;
        settings_applied++;
    endtask

    // Waits until every expected total has been taken and then lets the queue drain, so it holds no pixel.
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending_results != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic send_pair(input logic [PIX_W-1:0] cr, input logic [PIX_W-1:0] cg,
                             input logic [PIX_W-1:0] cb, input logic [PIX_W-1:0] tr,
                             input logic [PIX_W-1:0] tg, input logic [PIX_W-1:0] tb);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_cand_red   <= cr;
        s_cand_green <= cg;
        s_cand_blue  <= cb;
        s_tgt_red    <= tr;
        s_tgt_green  <= tg;
        s_tgt_blue   <= tb;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        pixel_pairs_sent++;
    endtask

    task automatic send_random_pair();
        send_pair(pick_channel(), pick_channel(), pick_channel(),
                  pick_channel(), pick_channel(), pick_channel());
    endtask

    initial begin
        logic [CFG_W-1:0]  side_v;
        logic [CFG_W-1:0]  strip_v;
        logic [MODE_W-1:0] mode_v;
        logic [2:0]        flip;
        int                eff_side;
        int                count;
        int                random_sent;
        int                phase;

        random_sent = 0;
        phase       = 0;
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Start a block under the reset settings, then shrink the side mid-block.
        send_pair(8'd255, 8'd0, 8'd128, 8'd0, 8'd255, 8'd128);
        send_pair(8'd10, 8'd20, 8'd30, 8'd13, 8'd24, 8'd35);
        send_pair(8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255);
        wait_idle();
        write_config(7'd2, RST_OVERLAP_WIDTH, MODE_LEFT);
        repeat (2) send_random_pair();

        // Zero-width strip: nothing counts.
        wait_idle();
        write_config(7'd2, 7'd0, MODE_LEFT);
        repeat (4) send_pair(8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0);

        // Side below the minimum with a strip wider than the block.
        wait_idle();
        write_config(7'd0, 7'd127, MODE_TOP);
        send_pair(8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255);
        send_pair(8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0);
        send_pair(8'd255, 8'd0, 8'd255, 8'd255, 8'd0, 8'd255);
        send_random_pair();

        wait_idle();
        write_config(7'd1, 7'd1, MODE_UNUSED);
        repeat (4) send_random_pair();

        wait_idle();
        write_config(7'd3, 7'd1, MODE_CORNER);
        repeat (9) send_random_pair();

        // Two full rows at the clamped largest side, every channel differing by the full
        // range; the pixels sent under the next settings close that block.
        wait_idle();
        write_config(7'd127, 7'd64, MODE_CORNER);
        repeat (2 * MAX_BLOCK_EDGE) begin
            flip = 3'($urandom);
            send_pair(flip[0] ? 8'd255 : 8'd0, flip[1] ? 8'd255 : 8'd0, flip[2] ? 8'd255 : 8'd0,
                      flip[0] ? 8'd0 : 8'd255, flip[1] ? 8'd0 : 8'd255, flip[2] ? 8'd0 : 8'd255);
        end

        // Random settings; phases need not end on a block boundary.
        while (random_sent < RANDOM_PAIRS) begin
            wait_idle();
            case ($urandom_range(0, 19))
                0:       side_v = CFG_W'($urandom_range(0, 1));
                1, 2, 3: side_v = CFG_W'($urandom_range(9, 16));
                default: side_v = CFG_W'($urandom_range(2, 8));
            endcase
            if (phase == STALL_PHASE)
                side_v = 7'd2;
            eff_side = (side_v < 2) ? 2 : int'(side_v);
            case ($urandom_range(0, 5))
                0:       strip_v = '0;
                1:       strip_v = CFG_W'($urandom_range(eff_side, 127));
                default: strip_v = CFG_W'($urandom_range(1, eff_side));
            endcase
            mode_v = MODE_W'($urandom_range(MODE_LEFT, MODE_UNUSED));
            write_config(side_v, strip_v, mode_v);
            if (phase == STALL_PHASE) begin
                stall_request = 1'b1;
                count = 80;
            end else if (eff_side > 8) begin
                count = eff_side * eff_side;
            end else if ($urandom_range(0, 3) != 0) begin
                count = eff_side * eff_side * int'($urandom_range(1, 4));
            end else begin
                count = int'($urandom_range(1, 40));
            end
            repeat (count) begin
                if (random_sent >= RANDOM_PAIRS - QUIET_TAIL)
                    quiet = 1'b1;
                send_random_pair();
                random_sent++;
            end
            phase++;
        end

        wait_idle();
        $display("Sent %0d pixel pairs under %0d register settings, the clamped side of 64 included.",
                 pixel_pairs_sent, settings_applied);
        $display("Compared %0d block totals; %0d failures.", results_checked, fail_count);
        if (fail_count == 0 && pending_results == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== overlap_ssd_error.f =====
rtl/ose_pkg.sv
rtl/ose_front.sv
rtl/ose_fifo.sv
rtl/ose_back.sv
rtl/overlap_ssd_error.sv
bench/overlap_error_checker.sv
bench/tb_overlap_ssd_error.sv
